// ----- rtl/core/towp_pkg.sv -----
// Shared constants and types for the time-of-week propagator.
// No dependencies; imported by towp_mod_pipe and time_of_week_propagator_unit.
`timescale 1ns / 1ps
`default_nettype none

package towp_pkg;

    localparam int TICKS_PER_MS    = 99375;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_INTERVAL_MS = 180000;
    localparam int WEEK_MS         = 604800000;

    localparam logic [63:0] MAX_TICKS = 64'(MAX_INTERVAL_MS) * 64'(TICKS_PER_MS);

    // floor(2^(32+FRAC_BITS) / TICKS_PER_MS), fits in 32 bits
    localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + FRAC_BITS)) / 64'(TICKS_PER_MS);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [16:0] TPM        = 17'(TICKS_PER_MS);

    localparam int REM_W      = 20;
    localparam int CORR_N     = 6;
    localparam int MOD_STAGES = 4;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [31:0] tow;
        logic signed [48:0] exact;
        logic [7:0]         al;
        logic               neg;
        logic [31:0]        mag;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/towp_mod_pipe.sv -----
// Pipelined remainder of a 32-bit magnitude by an 8-bit divisor, one byte per stage.
// Carries a side_t request alongside; depends on towp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module towp_mod_pipe
    import towp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire side_t      in_side,
    output side_t           out_side,
    output logic [7:0]      rem
);

    function automatic logic [7:0] rem_byte(input logic [7:0] r_in, input logic [7:0] bits,
                                            input logic [7:0] div);
        logic [8:0] t;
        logic [7:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, div})
            begin
                t = t - {1'b0, div};
            end
            r = t[7:0];
        end
        return r;
    endfunction

    side_t      side_reg  [MOD_STAGES];
    logic [7:0] rem_reg   [MOD_STAGES];
    side_t      side_next [MOD_STAGES];
    logic [7:0] rem_next  [MOD_STAGES];

    for (genvar g = 0; g < MOD_STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign side_next[g] = in_side;
            assign rem_next[g]  = rem_byte(8'd0, in_side.mag[31 -: 8], in_side.al);
        end
        else
        begin : g_rest
            assign side_next[g] = side_reg[g-1];
            assign rem_next[g]  = rem_byte(rem_reg[g-1], side_reg[g-1].mag[31-8*g -: 8],
                                           side_reg[g-1].al);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[g] <= '0;
                rem_reg[g]  <= '0;
            end
            else if (en)
            begin
                side_reg[g] <= side_next[g];
                rem_reg[g]  <= rem_next[g];
            end
        end
    end

    assign out_side = side_reg[MOD_STAGES-1];
    assign rem      = rem_reg[MOD_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/time_of_week_propagator_unit.sv -----
// Top level of the time-of-week propagator: tick-to-ms conversion, rounding,
// alignment, week wrap. Depends on towp_pkg and towp_mod_pipe.
//
//  Port group   Dir  Width  Contents
//  s_*          in   104    request: prev_tow, delta_ticks, align_ms
//  m_*          out  64     result: tow_ms, align_error, error_valid
//
// One request per cycle unless the output stalls. A request passes 7 conversion
// stages, 4 remainder stages, the alignment stage and the output register. The
// 32x32 reciprocal multiply and the byte-per-stage remainder set the stage count.
// Reset clears all valid bits. A stalled output freezes the whole pipeline;
// s_tready follows m_tready when the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module time_of_week_propagator_unit
    import towp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // prev_tow[30:0], delta_ticks[94:31], align_ms[102:95]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata   // tow_ms[30:0], align_error[55:31], error_valid[56]
);

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [30:0] old;
        logic [7:0]         al;
        logic [34:0]        dt;
        logic [63:0]        p_lo;
        logic [34:0]        p_hi;
    } sa_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [30:0] old;
        logic [7:0]         al;
        logic [34:0]        dt;
        logic [35:0]        est;
    } sb_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [30:0] old;
        logic [7:0]         al;
        logic [34:0]        dt;
        logic [35:0]        est;
        logic [52:0]        prod;
    } sc_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [30:0] old;
        logic [7:0]         al;
        logic [35:0]        est;
        logic [REM_W-1:0]   rem;
    } sd_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [30:0] old;
        logic [7:0]         al;
        logic [35:0]        dfx;
    } se_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic signed [31:0] tow;
        logic signed [48:0] exact;
    } sh_t;

    localparam logic signed [31:0] WEEK_S  = 32'(WEEK_MS);
    localparam logic signed [31:0] TOW_NEG = -32'sd1;
    localparam logic signed [48:0] ERR_MAX = 49'sd16777215;
    localparam logic signed [48:0] ERR_MIN = -49'sd16777216;
    localparam logic [48:0]        HALF    = 49'd1 << (FRAC_BITS - 1);

    logic        adv;
    sa_t         sa_reg, sa_next;
    sb_t         sb_reg, sb_next;
    sc_t         sc_reg, sc_next;
    sd_t         sd_reg, sd_next;
    se_t         se_reg, se_next;
    side_t       sf_reg, sf_next;
    side_t       sg_reg, sg_next;
    side_t       mod_side;
    logic [7:0]  mod_rem;
    sh_t         sh_reg, sh_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Stage A: range check and reciprocal partial products
    always_comb
    begin
        logic [63:0] dt_full;
        dt_full       = s_tdata[94:31];
        sa_next.valid = s_tvalid;
        sa_next.old   = s_tdata[30:0];
        sa_next.al    = s_tdata[102:95];
        sa_next.dt    = dt_full[34:0];
        sa_next.bad   = (s_tdata[30:0] == 31'h7FFF_FFFF) || (dt_full > MAX_TICKS);
        sa_next.p_lo  = {32'd0, dt_full[31:0]} * {32'd0, RECIP};
        sa_next.p_hi  = {32'd0, dt_full[34:32]} * {3'd0, RECIP};
    end

    // Stage B: quotient estimate
    always_comb
    begin
        logic [67:0] sum;
        sum           = {4'd0, sa_reg.p_lo} + {1'b0, sa_reg.p_hi, 32'd0};
        sb_next.valid = sa_reg.valid;
        sb_next.bad   = sa_reg.bad;
        sb_next.old   = sa_reg.old;
        sb_next.al    = sa_reg.al;
        sb_next.dt    = sa_reg.dt;
        sb_next.est   = sum[67:32];
    end

    // Stage C: back-multiply the estimate
    always_comb
    begin
        sc_next.valid = sb_reg.valid;
        sc_next.bad   = sb_reg.bad;
        sc_next.old   = sb_reg.old;
        sc_next.al    = sb_reg.al;
        sc_next.dt    = sb_reg.dt;
        sc_next.est   = sb_reg.est;
        sc_next.prod  = {17'd0, sb_reg.est} * {36'd0, TPM};
    end

    // Stage D: residue of the estimate
    always_comb
    begin
        logic [50:0] full;
        full          = {sc_reg.dt, {FRAC_BITS{1'b0}}} - sc_reg.prod[50:0];
        sd_next.valid = sc_reg.valid;
        sd_next.bad   = sc_reg.bad;
        sd_next.old   = sc_reg.old;
        sd_next.al    = sc_reg.al;
        sd_next.est   = sc_reg.est;
        sd_next.rem   = full[REM_W-1:0];
    end

    // Stage E: correct the estimate
    always_comb
    begin
        logic [2:0] corr;
        corr = 3'd0;
        for (int k = 1; k <= CORR_N; k++)
        begin
            if (sd_reg.rem >= REM_W'(k * TICKS_PER_MS))
            begin
                corr = 3'(k);
            end
        end
        se_next.valid = sd_reg.valid;
        se_next.bad   = sd_reg.bad;
        se_next.old   = sd_reg.old;
        se_next.al    = sd_reg.al;
        se_next.dfx   = sd_reg.est + {33'd0, corr};
    end

    // Stage F: exact time and half-up rounding
    always_comb
    begin
        logic [48:0] exact;
        logic [48:0] rounded;
        exact         = {{2{se_reg.old[30]}}, se_reg.old, {FRAC_BITS{1'b0}}}
                        + {13'd0, se_reg.dfx};
        rounded       = exact + HALF;
        sf_next.valid = se_reg.valid;
        sf_next.bad   = se_reg.bad;
        sf_next.exact = exact;
        sf_next.tow   = rounded[FRAC_BITS +: 32];
        sf_next.al    = se_reg.al;
        sf_next.neg   = 1'b0;
        sf_next.mag   = '0;
    end

    // Stage G: magnitude for the remainder unit
    always_comb
    begin
        sg_next     = sf_reg;
        sg_next.neg = sf_reg.tow[31];
        sg_next.mag = sf_reg.tow[31] ? 32'(-sf_reg.tow) : 32'(sf_reg.tow);
    end

    towp_mod_pipe u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_side  (sg_reg),
        .out_side (mod_side),
        .rem      (mod_rem)
    );

    // Stage H: snap to the alignment grid
    always_comb
    begin
        logic [7:0] rem_nn;
        logic [7:0] half_al;
        rem_nn  = (mod_side.neg && mod_rem != 8'd0) ? mod_side.al - mod_rem : mod_rem;
        half_al = mod_side.al >> 1;
        sh_next.valid = mod_side.valid;
        sh_next.bad   = mod_side.bad;
        sh_next.exact = mod_side.exact;
        sh_next.tow   = mod_side.tow;
        if (mod_side.al > 8'd1)
        begin
            if (rem_nn < half_al)
            begin
                sh_next.tow = mod_side.tow - $signed({24'd0, rem_nn});
            end
            else
            begin
                sh_next.tow = mod_side.tow + $signed({24'd0, 8'(mod_side.al - rem_nn)});
            end
        end
    end

    // Output: error saturation, week wrap, range check
    always_comb
    begin
        logic signed [48:0] diff;
        logic [24:0]        err;
        logic signed [31:0] wrapped;
        diff = $signed({sh_reg.tow[31], sh_reg.tow, {FRAC_BITS{1'b0}}}) - sh_reg.exact;
        if (diff > ERR_MAX)
        begin
            err = 25'h0FF_FFFF;
        end
        else if (diff < ERR_MIN)
        begin
            err = 25'h100_0000;
        end
        else
        begin
            err = diff[24:0];
        end
        if (sh_reg.tow < 0)
        begin
            wrapped = (sh_reg.tow == -WEEK_S) ? 32'sd0 : TOW_NEG;
        end
        else if (sh_reg.tow >= WEEK_S)
        begin
            wrapped = sh_reg.tow - WEEK_S;
        end
        else
        begin
            wrapped = sh_reg.tow;
        end
        out_valid_next = sh_reg.valid;
        if (sh_reg.bad)
        begin
            out_data_next = {7'd0, 1'b0, 25'd0, 31'h7FFF_FFFF};
        end
        else
        begin
            out_data_next = {7'd0, 1'b1, err, wrapped[30:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg        <= '0;
            sb_reg        <= '0;
            sc_reg        <= '0;
            sd_reg        <= '0;
            se_reg        <= '0;
            sf_reg        <= '0;
            sg_reg        <= '0;
            sh_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (adv)
        begin
            sa_reg        <= sa_next;
            sb_reg        <= sb_next;
            sc_reg        <= sc_next;
            sd_reg        <= sd_next;
            se_reg        <= se_next;
            sf_reg        <= sf_next;
            sg_reg        <= sg_next;
            sh_reg        <= sh_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[56] |-> m_tdata[30:0] == 31'h7FFF_FFFF && m_tdata[55:31] == 25'd0)
        else $error("unknown result carries a time or an error");

    a_tow_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:0] == 31'h7FFF_FFFF || m_tdata[30:0] < 31'd604800000)
        else $error("time of week out of range");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[55:31]) <= 25'sd8421376
                  && $signed(m_tdata[55:31]) >= -25'sd8421376)
        else $error("alignment error beyond half a grid step plus rounding");

endmodule

`default_nettype wire

// ----- dv/tow_result_checker.sv -----
// Watches both streams of time_of_week_propagator_unit, predicts each result
// and compares it field by field. Depends on towp_pkg.
`timescale 1ns / 1ps

module tow_result_checker
    import towp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,
    output int                fail_count,
    output int                tow_pending
);

    localparam longint TOW_INVALID = -1;
    localparam longint ERR_MAX     = (64'sd1 <<< 24) - 1;
    localparam longint ERR_MIN     = -(64'sd1 <<< 24);

    typedef struct packed {
        logic signed [30:0] tow;
        logic signed [24:0] err;
        logic               err_valid;
    } tow_result_t;

    tow_result_t tow_expect_q[$];
    tow_result_t want;
    tow_result_t got;

    initial begin
        fail_count  = 0;
        tow_pending = 0;
    end

    function automatic tow_result_t propagate_tow(logic [30:0] old_raw, logic [63:0] ticks,
                                                  logic [7:0] al_raw);
        longint          old;
        longint          one;
        longint          exact;
        longint          tow;
        longint          err;
        longint          wrapped;
        longint          al;
        longint          rem;
        longint unsigned tpm;
        longint unsigned q;
        longint unsigned r;
        longint unsigned dfx;
        tow_result_t     res;
        old = longint'($signed(old_raw));
        one = 64'sd1 <<< FRAC_BITS;
        tpm = TICKS_PER_MS;
        if (old == TOW_INVALID || ticks > MAX_TICKS)
        begin
            res.tow       = '1;
            res.err       = '0;
            res.err_valid = 1'b0;
            return res;
        end
        q     = ticks / tpm;
        r     = ticks % tpm;
        dfx   = (q << FRAC_BITS) + ((r << FRAC_BITS) / tpm);
        exact = old * one + longint'(dfx);
        tow   = (exact + (one >>> 1)) >>> FRAC_BITS;
        al    = longint'(al_raw);
        if (al > 1)
        begin
            rem = tow % al;
            if (rem < 0)
                rem += al;
            if (rem < (al >>> 1))
                tow -= rem;
            else
                tow += al - rem;
        end
        err = tow * one - exact;
        if (err > ERR_MAX)
            err = ERR_MAX;
        if (err < ERR_MIN)
            err = ERR_MIN;
        if (tow >= 0)
            wrapped = tow % longint'(WEEK_MS);
        else
            wrapped = -((-tow) % longint'(WEEK_MS));
        if (!(wrapped == TOW_INVALID || (wrapped >= 0 && wrapped < longint'(WEEK_MS))))
            wrapped = TOW_INVALID;
        res.tow       = wrapped[30:0];
        res.err       = err[24:0];
        res.err_valid = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint seen, longint wanted);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, seen, wanted);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tow_expect_q.push_back(propagate_tow(s_tdata[30:0], s_tdata[94:31],
                                                     s_tdata[102:95]));
            if (m_tvalid && m_tready)
            begin
                got.tow       = m_tdata[30:0];
                got.err       = m_tdata[55:31];
                got.err_valid = m_tdata[56];
                if (tow_expect_q.size() == 0)
                    report_mismatch("unexpected result, tow_ms", got.tow, 0);
                else
                begin
                    want = tow_expect_q.pop_front();
                    if (got.tow !== want.tow)
                        report_mismatch("tow_ms", got.tow, want.tow);
                    if (got.err !== want.err)
                        report_mismatch("align_error", got.err, want.err);
                    if (got.err_valid !== want.err_valid)
                        report_mismatch("error_valid", got.err_valid, want.err_valid);
                end
            end
            tow_pending <= tow_expect_q.size();
        end
    end

endmodule

// ----- dv/time_of_week_propagator_unit_tb.sv -----
// Top of the time_of_week_propagator_unit regression: clock, reset, stimulus
// and verdict. Depends on towp_pkg, the block and tow_result_checker.
`timescale 1ns / 1ps

module time_of_week_propagator_unit_tb;
    import towp_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_PER_PHASE = 470;
    localparam logic [30:0] TOW_INVALID = '1;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    int           fail_count;
    int           tow_pending;
    int           tx_idle_pct = 19;
    int           rx_idle_pct = 50;
    int           cycle_count = 0;

    time_of_week_propagator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tow_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .tow_pending (tow_pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("time_of_week_propagator_unit regression: fail");
            $finish;
        end
    end

    task automatic send_request(logic [30:0] old_tow, logic [63:0] ticks, logic [7:0] al);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, al, ticks, old_tow};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_request();
        logic [30:0] old_tow;
        logic [63:0] ticks;
        logic [7:0]  al;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            old_tow = TOW_INVALID;
        else if (pick < 18)
            old_tow = 31'($urandom);
        else if (pick < 23)
            old_tow = 31'(WEEK_MS - 1 - $urandom_range(0, 2000));
        else
            old_tow = 31'($urandom_range(0, WEEK_MS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            ticks = {$urandom, $urandom};
        else if (pick < 13)
            ticks = MAX_TICKS + 64'($urandom_range(0, 2)) - 64'd1;
        else if (pick < 40)
            ticks = 64'($urandom_range(0, 10 * TICKS_PER_MS));
        else
            ticks = {$urandom, $urandom} % (MAX_TICKS + 64'd1);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            al = 8'($urandom_range(0, 1));
        else if (pick < 50)
            al = 8'($urandom_range(250, 255));
        else
            al = 8'($urandom_range(2, 255));
        send_request(old_tow, ticks, al);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(TOW_INVALID, 64'd0, 8'd0);
        send_request(TOW_INVALID, MAX_TICKS, 8'd10);
        send_request(31'd0, 64'd0, 8'd0);
        send_request(31'd0, 64'd0, 8'd255);
        send_request(31'(WEEK_MS - 1), 64'd0, 8'd1);
        send_request(31'(WEEK_MS - 1), 64'(TICKS_PER_MS), 8'd0);
        send_request(31'(WEEK_MS - 1), 64'd49687, 8'd0);
        send_request(31'(WEEK_MS - 1), 64'd49688, 8'd0);
        send_request(31'd1000, MAX_TICKS, 8'd2);
        send_request(31'd1000, MAX_TICKS + 64'd1, 8'd2);
        send_request(31'd1000, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
        send_request(31'h7FFF_FFFE, 64'd0, 8'd0);
        send_request(31'h4000_0000, MAX_TICKS, 8'd3);
        send_request(31'h3FFF_FFFF, MAX_TICKS, 8'd255);
        send_request(31'h3FFF_FFFF, 64'd0, 8'd0);
        send_request(31'h7FFF_FFFB, 64'd12345, 8'd10);
        send_request(31'd7, 64'd0, 8'd2);
        send_request(31'd8, 64'd0, 8'd3);
        send_request(31'd1234567, 64'd99374, 8'd128);
        send_request(31'd1234567, 64'd1, 8'd127);
        send_request(31'd500, 64'h5555_5555, 8'hAA);
        send_request(31'h2AAA_AAAA, 64'h2_AAAA_AAAA, 8'h55);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 19; rx_idle_pct = 50; end
                1: begin tx_idle_pct = 50; rx_idle_pct = 19; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_request();
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (tow_pending != 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && tow_pending == 0)
            $display("time_of_week_propagator_unit regression: pass");
        else
            $display("time_of_week_propagator_unit regression: fail");
        $finish;
    end

endmodule

// ----- time_of_week_propagator_unit.f -----
rtl/core/towp_pkg.sv
rtl/core/towp_mod_pipe.sv
rtl/core/time_of_week_propagator_unit.sv
dv/tow_result_checker.sv
dv/time_of_week_propagator_unit_tb.sv
